[rtl/rrpd_pkg.sv]
// Shared types and constants for the rounded-rectangle pixel dimmer.
`default_nettype none

package rrpd_pkg;

   localparam int MAX_DIM_DEFAULT = 1024;

   localparam int CHAN_W     = 8;
   localparam int CHAN_N     = 3;
   localparam int PIX_W      = CHAN_W * CHAN_N;
   localparam int PROD_W     = 2 * CHAN_W;
   localparam int DIM_REG_W  = 11;
   localparam int RAD_REG_W  = 15;
   localparam int OPA_W      = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CHAN_W-1:0] ROUND_BIAS = 8'd127;

   // Channel 0 (red) sits in the lowest bits.
   typedef logic [CHAN_N-1:0][CHAN_W-1:0] pixel_type;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_CORNER_RADIUS = 2'd2,
      CSR_PRESS_OPACITY = 2'd3
   } csr_reg_type;

endpackage

`default_nettype wire

[rtl/rrpd_raster.sv]
// Raster position counters, effective frame geometry and clamped corner radius.
`default_nettype none

module rrpd_raster
   import rrpd_pkg::*;
#(
   parameter int  MAX_DIM = MAX_DIM_DEFAULT,
   localparam int CW      = $clog2(MAX_DIM),
   localparam int DW      = $clog2(MAX_DIM + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [DIM_REG_W-1:0] frame_width,
   input  wire logic [DIM_REG_W-1:0] frame_height,
   input  wire logic [RAD_REG_W-1:0] corner_radius,
   output logic      [DW-1:0]        eff_width,
   output logic      [DW-1:0]        eff_height,
   output logic      [DW-1:0]        eff_radius,
   output logic      [CW-1:0]        pos_x,
   output logic      [CW-1:0]        pos_y,
   output logic                      frame_last
);

   localparam int EW = (DW > DIM_REG_W) ? DW : DIM_REG_W;
   localparam int RW = (DW > RAD_REG_W) ? DW : RAD_REG_W;

   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [EW-1:0] fw_ext, fh_ext;
   logic [DW-1:0] half;
   logic          last_col, last_row;

   assign fw_ext = EW'(frame_width);
   assign fh_ext = EW'(frame_height);

   always_comb begin
      if (fw_ext == '0) begin
         eff_width = DW'(1);
      end else if (fw_ext > EW'(MAX_DIM)) begin
         eff_width = DW'(MAX_DIM);
      end else begin
         eff_width = DW'(fw_ext);
      end
      if (fh_ext == '0) begin
         eff_height = DW'(1);
      end else if (fh_ext > EW'(MAX_DIM)) begin
         eff_height = DW'(MAX_DIM);
      end else begin
         eff_height = DW'(fh_ext);
      end
   end

   // Radius is limited to half the smaller side.
   assign half       = ((eff_width < eff_height) ? eff_width : eff_height) >> 1;
   assign eff_radius = (RW'(corner_radius) < RW'(half)) ? DW'(corner_radius) : half;

   // A counter left beyond the bound by a register write acts as the last position.
   assign pos_x = (DW'(col_ff) >= eff_width)  ? CW'(eff_width - DW'(1))  : col_ff;
   assign pos_y = (DW'(row_ff) >= eff_height) ? CW'(eff_height - DW'(1)) : row_ff;

   assign last_col   = (pos_x == CW'(eff_width - DW'(1)));
   assign last_row   = (pos_y == CW'(eff_height - DW'(1)));
   assign frame_last = last_col && last_row;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : pos_y + CW'(1);
         end else begin
            col_in = pos_x + CW'(1);
            row_in = pos_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

`ifndef SYNTH
   a_wrap_at_frame_end: assert property (@(posedge clock) disable iff (reset)
      accept && frame_last |=> col_ff == '0 && row_ff == '0)
      else $error("counters did not wrap after the last pixel of the frame");

   a_column_advance: assert property (@(posedge clock) disable iff (reset)
      accept && !last_col |=> col_ff == $past(pos_x) + CW'(1) && row_ff == $past(pos_y))
      else $error("column counter did not advance within a row");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(col_ff) && $stable(row_ff))
      else $error("position moved without an accepted transaction");
`endif

endmodule

`default_nettype wire

[rtl/rrpd_shape.sv]
// Rounded-rectangle membership test: squared corner distances, then compare.
`default_nettype none

module rrpd_shape
   import rrpd_pkg::*;
#(
   parameter int  MAX_DIM = MAX_DIM_DEFAULT,
   localparam int CW      = $clog2(MAX_DIM),
   localparam int DW      = $clog2(MAX_DIM + 1)
) (
   input  wire logic          clock,
   input  wire logic          load,
   input  wire logic [CW-1:0] pos_x,
   input  wire logic [CW-1:0] pos_y,
   input  wire logic [DW-1:0] eff_width,
   input  wire logic [DW-1:0] eff_height,
   input  wire logic [DW-1:0] eff_radius,
   output logic               in_shape
);

   localparam int SQ_W = 2 * DW + 1;

   logic [DW-1:0]   xe, ye, w_in, h_in, r_dbl;
   logic            x_lo, x_hi, y_lo, y_hi, bypass_in;
   logic [DW:0]     ax_full, ay_full;
   logic [CW-1:0]   ax, ay;
   logic [2*CW-1:0] ax_sq_in, ay_sq_in;
   logic [2*DW-1:0] r_sq_in;

   logic            bypass_ff;
   logic [2*CW-1:0] ax_sq_ff, ay_sq_ff;
   logic [2*DW-1:0] r_sq_ff;

   always_comb begin
      xe   = DW'(pos_x);
      ye   = DW'(pos_y);
      w_in = eff_width - eff_radius;
      h_in = eff_height - eff_radius;
      x_lo = xe < eff_radius;
      x_hi = xe >= w_in;
      y_lo = ye < eff_radius;
      y_hi = ye >= h_in;
      bypass_in = (eff_radius == '0) || (!x_lo && !x_hi) || (!y_lo && !y_hi);
      // Distance from the half-pixel corner centre, in doubled coordinates.
      ax_full = x_lo ? (({1'b0, eff_radius - xe} << 1) - (DW + 1)'(1))
                     : (({1'b0, xe - w_in} << 1) + (DW + 1)'(1));
      ay_full = y_lo ? (({1'b0, eff_radius - ye} << 1) - (DW + 1)'(1))
                     : (({1'b0, ye - h_in} << 1) + (DW + 1)'(1));
      ax    = CW'(ax_full);
      ay    = CW'(ay_full);
      r_dbl = eff_radius << 1;
      ax_sq_in = (2 * CW)'(ax) * (2 * CW)'(ax);
      ay_sq_in = (2 * CW)'(ay) * (2 * CW)'(ay);
      r_sq_in  = (2 * DW)'(r_dbl) * (2 * DW)'(r_dbl);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bypass_ff <= bypass_in;
         ax_sq_ff  <= ax_sq_in;
         ay_sq_ff  <= ay_sq_in;
         r_sq_ff   <= r_sq_in;
      end
   end

   assign in_shape = bypass_ff ||
                     ((SQ_W'(ax_sq_ff) + SQ_W'(ay_sq_ff)) <= SQ_W'(r_sq_ff));

endmodule

`default_nettype wire

[rtl/rrpd_scale.sv]
// Per-channel darkening: product with the retained level, then divide by 255.
`default_nettype none

module rrpd_scale
   import rrpd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             load,
   input  wire pixel_type        pixel,
   input  wire logic [OPA_W-1:0] press_opacity,
   output pixel_type             raw,
   output pixel_type             scaled
);

   logic [CHAN_W-1:0]                 retained;
   logic [CHAN_N-1:0][PROD_W-1:0]     prod_in, prod_ff, quot_sum;
   pixel_type                         raw_ff;

   // 255 minus opacity
   assign retained = ~press_opacity;

   always_comb begin
      for (int i = 0; i < CHAN_N; i++) begin
         prod_in[i] = PROD_W'(pixel[i]) * PROD_W'(retained) + PROD_W'(ROUND_BIAS);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         raw_ff  <= pixel;
      end
   end

   // v / 255 == (v + (v >> 8) + 1) >> 8 over the whole product range.
   always_comb begin
      for (int i = 0; i < CHAN_N; i++) begin
         quot_sum[i] = prod_ff[i] + (prod_ff[i] >> CHAN_W) + PROD_W'(1);
         scaled[i]   = quot_sum[i][PROD_W-1:CHAN_W];
      end
   end

   assign raw = raw_ff;

endmodule

`default_nettype wire

[rtl/rounded_rect_pixel_dimmer.sv]
// Top level of the rounded-rectangle pixel dimmer: register port and pipeline.
// Takes one RGB888 pixel per clock in raster order and darkens those inside a
// rounded rectangle that covers the configured frame; corner pixels outside the
// circle pass unchanged. Throughput is one pixel per cycle while the result
// port is not stalled; each pixel passes through three register stages (input
// register, product and square register, result register) before its result
// is shown on the result port. A stalled result stage fills
// the earlier stages before req_tready drops. Write the geometry and opacity
// registers only while no pixel is in flight; they take effect from the next
// pixel and do not clear the position counters.
`default_nettype none

module rounded_rect_pixel_dimmer
   import rrpd_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [PIX_W-1:0]      req_tdata,  // in_red, in_green, in_blue
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [PIX_W-1:0]      rsp_tdata,  // out_red, out_green, out_blue
   output logic                       rsp_tuser,  // inside_shape
   output logic                       rsp_tlast   // frame_end
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int DW = $clog2(MAX_DIM + 1);

   logic [DIM_REG_W-1:0] frame_width_ff, frame_height_ff;
   logic [RAD_REG_W-1:0] corner_radius_ff;
   logic [OPA_W-1:0]     press_opacity_ff;
   csr_reg_type          csr_sel;
   logic                 csr_write;

   logic [DW-1:0] eff_width, eff_height, eff_radius;
   logic [CW-1:0] pos_x, pos_y;
   logic          frame_last;
   logic          accept;

   logic          ready_a, ready_b, ready_c, load_b, load_c;
   logic          v_a_ff, v_a_in, v_b_ff, v_b_in, v_c_ff, v_c_in;
   pixel_type     pix_a_ff;
   logic [CW-1:0] x_a_ff, y_a_ff;
   logic          last_a_ff, last_b_ff, last_c_ff;
   logic          in_shape;
   pixel_type     raw, scaled, rsp_data_ff, rsp_data_in;
   logic          inside_c_ff;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= DIM_REG_W'(1);
         frame_height_ff  <= DIM_REG_W'(1);
         corner_radius_ff <= '0;
         press_opacity_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_sel)
            CSR_FRAME_WIDTH:   frame_width_ff   <= csr_pwdata[DIM_REG_W-1:0];
            CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_pwdata[DIM_REG_W-1:0];
            CSR_CORNER_RADIUS: corner_radius_ff <= csr_pwdata[RAD_REG_W-1:0];
            CSR_PRESS_OPACITY: press_opacity_ff <= csr_pwdata[OPA_W-1:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_FRAME_WIDTH:   csr_prdata = CSR_DATA_W'(frame_width_ff);
         CSR_FRAME_HEIGHT:  csr_prdata = CSR_DATA_W'(frame_height_ff);
         CSR_CORNER_RADIUS: csr_prdata = CSR_DATA_W'(corner_radius_ff);
         CSR_PRESS_OPACITY: csr_prdata = CSR_DATA_W'(press_opacity_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   assign ready_c    = !v_c_ff || rsp_tready;
   assign ready_b    = !v_b_ff || ready_c;
   assign ready_a    = !v_a_ff || ready_b;
   assign req_tready = ready_a;
   assign accept     = req_tvalid && ready_a;
   assign load_b     = ready_b && v_a_ff;
   assign load_c     = ready_c && v_b_ff;

   assign v_a_in = ready_a ? req_tvalid : v_a_ff;
   assign v_b_in = ready_b ? v_a_ff : v_b_ff;
   assign v_c_in = ready_c ? v_b_ff : v_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
         v_c_ff <= 1'b0;
      end else begin
         v_a_ff <= v_a_in;
         v_b_ff <= v_b_in;
         v_c_ff <= v_c_in;
      end
   end

   // ---------------- position ----------------
   rrpd_raster #(
      .MAX_DIM (MAX_DIM)
   ) u_raster (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .frame_width   (frame_width_ff),
      .frame_height  (frame_height_ff),
      .corner_radius (corner_radius_ff),
      .eff_width     (eff_width),
      .eff_height    (eff_height),
      .eff_radius    (eff_radius),
      .pos_x         (pos_x),
      .pos_y         (pos_y),
      .frame_last    (frame_last)
   );

   // Input register: capture pixel with its position.
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_a_ff  <= pixel_type'(req_tdata);
         x_a_ff    <= pos_x;
         y_a_ff    <= pos_y;
         last_a_ff <= frame_last;
      end
   end

   // ---------------- second stage ----------------
   rrpd_shape #(
      .MAX_DIM (MAX_DIM)
   ) u_shape (
      .clock      (clock),
      .load       (load_b),
      .pos_x      (x_a_ff),
      .pos_y      (y_a_ff),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .eff_radius (eff_radius),
      .in_shape   (in_shape)
   );

   rrpd_scale u_scale (
      .clock         (clock),
      .load          (load_b),
      .pixel         (pix_a_ff),
      .press_opacity (press_opacity_ff),
      .raw           (raw),
      .scaled        (scaled)
   );

   always_ff @(posedge clock) begin
      if (load_b) begin
         last_b_ff <= last_a_ff;
      end
   end

   // ---------------- result register ----------------
   assign rsp_data_in = in_shape ? scaled : raw;

   always_ff @(posedge clock) begin
      if (load_c) begin
         rsp_data_ff <= rsp_data_in;
         inside_c_ff <= in_shape;
         last_c_ff   <= last_b_ff;
      end
   end

   assign rsp_tvalid = v_c_ff;
   assign rsp_tdata  = PIX_W'(rsp_data_ff);
   assign rsp_tuser  = inside_c_ff;
   assign rsp_tlast  = last_c_ff;

`ifndef SYNTH
   a_accept_fills_input: assert property (@(posedge clock) disable iff (reset)
      accept |=> v_a_ff)
      else $error("accepted transaction missing from the input register");

   a_mid_stage_holds: assert property (@(posedge clock) disable iff (reset)
      v_b_ff && !ready_c |=> v_b_ff && $stable(last_b_ff))
      else $error("middle stage lost or changed a stalled transaction");

   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      v_a_ff && v_b_ff && v_c_ff && !rsp_tready |-> !req_tready)
      else $error("input accepted while the pipeline is full and stalled");
`endif

endmodule

`default_nettype wire
